### hdl/assert_macros.svh
// Shared assertion macros, clocked on clk with reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in every cycle outside reset.
`define MRB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MRB_ASSERT_IMPL(lbl, ante, cons, msg) \
    `MRB_ASSERT_ALWAYS(lbl, (ante) |-> (cons), msg)

`endif

### hdl/mrb_pkg.sv
package mrb_pkg;

    localparam int MUTEX_COUNT  = 16;
    localparam int TASK_ID_BITS = 8;
    localparam int COUNT_BITS   = 8;
    localparam int IDX_W        = $clog2(MUTEX_COUNT);

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_ACQUIRE = 3'd1,
        OP_RELEASE = 3'd2,
        OP_DESTROY = 3'd3,
        OP_QUERY   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        RS_OK        = 3'd0,
        RS_DESTROYED = 3'd1,
        RS_DEADLOCK  = 3'd2,
        RS_BUSY      = 3'd3,
        RS_NOPERM    = 3'd4,
        RS_FULL      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        LS_UNLOCKED  = 2'd0,
        LS_LOCKED    = 2'd1,
        LS_DESTROYED = 2'd2
    } lock_state_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [3:0] mutex_index;
        logic [7:0] task_id;
        logic       recursive_flag;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic       is_locked;
        logic       owner_present;
        logic [7:0] owner_task;
        logic [7:0] hold_depth;
    } rsp_t;

    typedef struct packed {
        lock_state_t             lock_state;
        logic [TASK_ID_BITS-1:0] holder_id;
        logic                    holder_valid;
        logic [COUNT_BITS-1:0]   hold_count;
        logic                    recursive_mode;
    } entry_t;

endpackage

### hdl/mrb_update.sv
// Next-state and response for one request against one mutex record.
module mrb_update (
    input  mrb_pkg::req_t   req,
    input  logic            in_range,
    input  mrb_pkg::entry_t cur,
    output mrb_pkg::entry_t nxt,
    output mrb_pkg::rsp_t   rsp
);

    logic [mrb_pkg::TASK_ID_BITS-1:0] task_w;
    logic                             owns;
    mrb_pkg::status_t                 status;

    assign task_w = req.task_id[mrb_pkg::TASK_ID_BITS-1:0];
    assign owns   = cur.holder_valid && (cur.holder_id == task_w);

    always_comb
    begin
        nxt    = cur;
        status = mrb_pkg::RS_OK;
        case (req.req_type)
            mrb_pkg::OP_CREATE:
            begin
                nxt.lock_state     = mrb_pkg::LS_UNLOCKED;
                nxt.holder_id      = '0;
                nxt.holder_valid   = 1'b0;
                nxt.hold_count     = '0;
                nxt.recursive_mode = req.recursive_flag;
            end
            mrb_pkg::OP_ACQUIRE:
            begin
                if (cur.lock_state == mrb_pkg::LS_DESTROYED)
                begin
                    status = mrb_pkg::RS_DESTROYED;
                end
                else if (owns)
                begin
                    if (!cur.recursive_mode)
                    begin
                        status = mrb_pkg::RS_DEADLOCK;
                    end
                    else if (&cur.hold_count)
                    begin
                        status = mrb_pkg::RS_FULL;
                    end
                    else
                    begin
                        nxt.hold_count = cur.hold_count + 1'b1;
                    end
                end
                else if (cur.lock_state == mrb_pkg::LS_UNLOCKED)
                begin
                    nxt.lock_state   = mrb_pkg::LS_LOCKED;
                    nxt.holder_id    = task_w;
                    nxt.holder_valid = 1'b1;
                    nxt.hold_count   = mrb_pkg::COUNT_BITS'(1);
                end
                else
                begin
                    status = mrb_pkg::RS_BUSY;
                end
            end
            mrb_pkg::OP_RELEASE:
            begin
                if (cur.lock_state == mrb_pkg::LS_DESTROYED)
                begin
                    status = mrb_pkg::RS_DESTROYED;
                end
                else if (!owns || cur.lock_state != mrb_pkg::LS_LOCKED
                         || cur.hold_count == '0)
                begin
                    status = mrb_pkg::RS_NOPERM;
                end
                else
                begin
                    nxt.hold_count = cur.hold_count - 1'b1;
                    if (cur.hold_count == mrb_pkg::COUNT_BITS'(1))
                    begin
                        nxt.holder_id    = '0;
                        nxt.holder_valid = 1'b0;
                        nxt.lock_state   = mrb_pkg::LS_UNLOCKED;
                    end
                end
            end
            mrb_pkg::OP_DESTROY:
            begin
                if (cur.lock_state == mrb_pkg::LS_LOCKED)
                begin
                    status = mrb_pkg::RS_BUSY;
                end
                else
                begin
                    nxt.lock_state   = mrb_pkg::LS_DESTROYED;
                    nxt.holder_id    = '0;
                    nxt.holder_valid = 1'b0;
                    nxt.hold_count   = '0;
                end
            end
            mrb_pkg::OP_QUERY:
            begin
                if (cur.lock_state == mrb_pkg::LS_DESTROYED)
                begin
                    status = mrb_pkg::RS_DESTROYED;
                end
            end
            default:
            begin
                status = mrb_pkg::RS_NOPERM;
            end
        endcase
    end

    always_comb
    begin
        if (in_range)
        begin
            rsp.status        = status;
            rsp.is_locked     = (nxt.lock_state == mrb_pkg::LS_LOCKED);
            rsp.owner_present = nxt.holder_valid;
            rsp.owner_task    = nxt.holder_valid ? 8'(nxt.holder_id) : 8'd0;
            rsp.hold_depth    = 8'(nxt.hold_count);
        end
        else
        begin
            rsp.status        = mrb_pkg::RS_DESTROYED;
            rsp.is_locked     = 1'b0;
            rsp.owner_present = 1'b0;
            rsp.owner_task    = 8'd0;
            rsp.hold_depth    = 8'd0;
        end
    end

endmodule

### hdl/recursive_mutex_bank_top.sv
// A word taken with start is registered into req_reg, then its result into rsp;
// the result shows with rsp_valid for one cycle.
// Throughput: one request per cycle; busy stays low, the record table
// updates each cycle so back-to-back requests on one mutex see fresh state.
// Reset (async, rst_n low): all mutexes unlocked, no owner, count zero,
// non-recursive; no result pending. The receiver cannot stall.
module recursive_mutex_bank_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mrb_pkg::req_t req,
    output logic          rsp_valid,
    output mrb_pkg::rsp_t rsp
);

    // Stage 1: request register.
    logic            req_valid_reg;
    mrb_pkg::req_t   req_reg;

    // Per-mutex records, small enough for flops with a plain reset.
    mrb_pkg::entry_t entry_reg [mrb_pkg::MUTEX_COUNT];

    // Stage 2: result register.
    logic            rsp_valid_reg;
    mrb_pkg::rsp_t   rsp_reg;

    logic [mrb_pkg::IDX_W-1:0] idx;
    logic                      in_range;
    mrb_pkg::entry_t           cur;
    mrb_pkg::entry_t           entry_next;
    mrb_pkg::rsp_t             rsp_next;

    // Never stalls: each request is a single read-modify-write of one record.
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
    end

    // Record lookup; indexes past the bank answer as destroyed and write nothing.
    assign idx      = req_reg.mutex_index[mrb_pkg::IDX_W-1:0];
    assign in_range = (32'(req_reg.mutex_index) < mrb_pkg::MUTEX_COUNT);
    assign cur      = entry_reg[idx];

    mrb_update u_update (
        .req      (req_reg),
        .in_range (in_range),
        .cur      (cur),
        .nxt      (entry_next),
        .rsp      (rsp_next)
    );

    // Write-back lands at the same edge the result is registered, so the
    // next request, now in req_reg, reads the updated record.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mrb_pkg::MUTEX_COUNT; i++)
            begin
                entry_reg[i] <= '{lock_state:     mrb_pkg::LS_UNLOCKED,
                                  holder_id:      '0,
                                  holder_valid:   1'b0,
                                  hold_count:     '0,
                                  recursive_mode: 1'b0};
            end
        end
        else if (req_valid_reg && in_range)
        begin
            entry_reg[idx] <= entry_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### hdl/mrb_checker.sv
`include "assert_macros.svh"

module mrb_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          rsp_valid,
    input mrb_pkg::rsp_t rsp
);

    // every accepted word yields a result
    `MRB_ASSERT_IMPL(a_latency, start && !busy, ##2 rsp_valid, "result missing after accept")
    // no result without a request before it
    `MRB_ASSERT_IMPL(a_no_spurious, rsp_valid, $past(start && !busy, 2), "unrequested result")
    // locked and owned always go together
    `MRB_ASSERT_IMPL(a_lock_owner, rsp_valid, rsp.is_locked == rsp.owner_present, "lock/owner mismatch")
    // a locked mutex holds a nonzero count, a free one reads owner zero
    `MRB_ASSERT_IMPL(a_lock_count, rsp_valid, (rsp.is_locked && rsp.hold_depth != 8'd0) || (!rsp.is_locked && rsp.owner_task == 8'd0), "bad count or owner")

endmodule

bind recursive_mutex_bank_top mrb_checker u_mrb_checker (.*);
